// File: design/bls_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper package
// Shared widths, reset values and item codes of the line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int WIDTH_BITS     = 11;
    localparam int ADDR_BITS      = 22;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 11'd512;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } mode_t;

    // Two-bit signed step direction.
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;
    localparam logic [1:0] DIR_NONE = 2'b00;

endpackage

// File: design/bresenham_line_stepper_top.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper
// Integer line rasterizer: a load beat sets up a line between two endpoints,
// each step on a live line returns the next pixel with its RGB888 byte address.
//
//   Channel  Direction  Payload                                        Notes
//   s_       in         mode, start_x, start_y, end_x, end_y           load/step
//   m_       out        pixel_x, pixel_y, byte_address, last_pixel     live steps
//   cfg_     in         image width                                    write only
//
// A beat is held in the input register and then moves to the result
// register, which puts its pixel on the result port; the address multiply
// and the decision update sit in the single stage between the two registers.
// One beat is taken every cycle unless a stalled result holds the input stage.
// Reset is synchronous and active low; it drops the current line and sets
// the image width to 512. A stalled result register holds the input stage
// only when the waiting input beat is a step that yields a pixel.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_top #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bls_pkg::WIDTH_BITS-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  logic [COORD_BITS-1:0]          s_start_x,
    input  logic [COORD_BITS-1:0]          s_start_y,
    input  logic [COORD_BITS-1:0]          s_end_x,
    input  logic [COORD_BITS-1:0]          s_end_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [COORD_BITS-1:0]          m_pixel_x,
    output logic [COORD_BITS-1:0]          m_pixel_y,
    output logic [bls_pkg::ADDR_BITS-1:0]  m_byte_address,
    output logic                           m_last_pixel
);

    logic [bls_pkg::WIDTH_BITS-1:0] image_width_reg;

    logic                  in_valid_reg;
    bls_pkg::mode_t        in_mode_reg;
    logic [COORD_BITS-1:0] in_start_x_reg;
    logic [COORD_BITS-1:0] in_start_y_reg;
    logic [COORD_BITS-1:0] in_end_x_reg;
    logic [COORD_BITS-1:0] in_end_y_reg;

    logic                  active_reg;
    logic [COORD_BITS-1:0] cur_col_reg;
    logic [COORD_BITS-1:0] cur_row_reg;
    logic [COORD_BITS-1:0] target_col_reg;
    logic [COORD_BITS-1:0] target_row_reg;
    logic [1:0]            col_dir_reg;
    logic [1:0]            row_dir_reg;
    logic [COORD_BITS:0]   twice_dcol_reg;
    logic [COORD_BITS:0]   twice_drow_reg;
    logic [COORD_BITS+2:0] decision_reg;
    logic                  row_major_reg;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [COORD_BITS-1:0]         m_pixel_x_reg;
    logic [COORD_BITS-1:0]         m_pixel_y_reg;
    logic [bls_pkg::ADDR_BITS-1:0] m_byte_address_reg;
    logic                          m_last_pixel_reg;

    logic [1:0]                    setup_col_dir;
    logic [1:0]                    setup_row_dir;
    logic [COORD_BITS:0]           setup_twice_dcol;
    logic [COORD_BITS:0]           setup_twice_drow;
    logic [COORD_BITS+2:0]         setup_decision;
    logic                          setup_row_major;

    logic [COORD_BITS-1:0]         step_next_col;
    logic [COORD_BITS-1:0]         step_next_row;
    logic [COORD_BITS+2:0]         step_next_decision;
    logic [bls_pkg::ADDR_BITS-1:0] step_byte_address;
    logic                          step_last_pixel;

    logic out_free;
    logic produce;
    logic advance;
    logic in_take;

    bls_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x    (in_start_x_reg),
        .start_y    (in_start_y_reg),
        .end_x      (in_end_x_reg),
        .end_y      (in_end_y_reg),
        .col_dir    (setup_col_dir),
        .row_dir    (setup_row_dir),
        .twice_dcol (setup_twice_dcol),
        .twice_drow (setup_twice_drow),
        .decision   (setup_decision),
        .row_major  (setup_row_major)
    );

    bls_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .image_width   (image_width_reg),
        .cur_col       (cur_col_reg),
        .cur_row       (cur_row_reg),
        .target_col    (target_col_reg),
        .target_row    (target_row_reg),
        .col_dir       (col_dir_reg),
        .row_dir       (row_dir_reg),
        .twice_dcol    (twice_dcol_reg),
        .twice_drow    (twice_drow_reg),
        .decision      (decision_reg),
        .row_major     (row_major_reg),
        .next_col      (step_next_col),
        .next_row      (step_next_row),
        .next_decision (step_next_decision),
        .byte_address  (step_byte_address),
        .last_pixel    (step_last_pixel)
    );

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        produce  = (in_mode_reg == bls_pkg::MODE_STEP) && active_reg;
        advance  = in_valid_reg && (!produce || out_free);
        s_ready  = !in_valid_reg || advance;
        in_take  = s_valid && s_ready;

        m_valid_next = m_valid_reg && !m_ready;
        if (advance && produce) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= bls_pkg::WIDTH_RESET;
            in_valid_reg    <= 1'b0;
            active_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                image_width_reg <= cfg_wr_data;
            end

            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            m_valid_reg <= m_valid_next;

            if (advance) begin
                if (in_mode_reg == bls_pkg::MODE_LOAD) begin
                    active_reg <= 1'b1;
                end else if (active_reg) begin
                    active_reg <= !step_last_pixel;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_mode_reg    <= bls_pkg::mode_t'(s_mode);
            in_start_x_reg <= s_start_x;
            in_start_y_reg <= s_start_y;
            in_end_x_reg   <= s_end_x;
            in_end_y_reg   <= s_end_y;
        end

        if (advance) begin
            if (in_mode_reg == bls_pkg::MODE_LOAD) begin
                cur_col_reg    <= in_start_x_reg;
                cur_row_reg    <= in_start_y_reg;
                target_col_reg <= in_end_x_reg;
                target_row_reg <= in_end_y_reg;
                col_dir_reg    <= setup_col_dir;
                row_dir_reg    <= setup_row_dir;
                twice_dcol_reg <= setup_twice_dcol;
                twice_drow_reg <= setup_twice_drow;
                decision_reg   <= setup_decision;
                row_major_reg  <= setup_row_major;
            end else if (active_reg && !step_last_pixel) begin
                cur_col_reg  <= step_next_col;
                cur_row_reg  <= step_next_row;
                decision_reg <= step_next_decision;
            end
        end

        if (advance && produce) begin
            m_pixel_x_reg      <= cur_col_reg;
            m_pixel_y_reg      <= cur_row_reg;
            m_byte_address_reg <= step_byte_address;
            m_last_pixel_reg   <= step_last_pixel;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = m_pixel_x_reg;
    assign m_pixel_y      = m_pixel_y_reg;
    assign m_byte_address = m_byte_address_reg;
    assign m_last_pixel   = m_last_pixel_reg;

endmodule

// File: design/bls_setup.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper setup
// Derives step directions, doubled deltas, major axis and the initial
// decision term from the two endpoints of a new line.
// ----------------------------------------------------------------------------
module bls_setup #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic [1:0]            col_dir,
    output logic [1:0]            row_dir,
    output logic [COORD_BITS:0]   twice_dcol,
    output logic [COORD_BITS:0]   twice_drow,
    output logic [COORD_BITS+2:0] decision,
    output logic                  row_major
);

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   dx_neg;
    logic [COORD_BITS:0]   dy_neg;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;

    always_comb begin
        dx     = {1'b0, end_x} - {1'b0, start_x};
        dy     = {1'b0, end_y} - {1'b0, start_y};
        dx_neg = ~dx + 1'b1;
        dy_neg = ~dy + 1'b1;
        adx    = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ady    = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

        if (dx[COORD_BITS]) begin
            col_dir = bls_pkg::DIR_NEG;
        end else if (adx != '0) begin
            col_dir = bls_pkg::DIR_POS;
        end else begin
            col_dir = bls_pkg::DIR_NONE;
        end
        if (dy[COORD_BITS]) begin
            row_dir = bls_pkg::DIR_NEG;
        end else if (ady != '0) begin
            row_dir = bls_pkg::DIR_POS;
        end else begin
            row_dir = bls_pkg::DIR_NONE;
        end

        twice_dcol = {adx, 1'b0};
        twice_drow = {ady, 1'b0};
        row_major  = ady > adx;
        if (row_major) begin
            decision = {2'b00, adx, 1'b0} - {3'b000, ady};
        end else begin
            decision = {2'b00, ady, 1'b0} - {3'b000, adx};
        end
    end

endmodule

// File: design/bls_step.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper step datapath
// Forms the current pixel with its byte address and end flag, and the
// position and decision term of the following pixel.
// ----------------------------------------------------------------------------
module bls_step #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic [bls_pkg::WIDTH_BITS-1:0] image_width,
    input  logic [COORD_BITS-1:0]          cur_col,
    input  logic [COORD_BITS-1:0]          cur_row,
    input  logic [COORD_BITS-1:0]          target_col,
    input  logic [COORD_BITS-1:0]          target_row,
    input  logic [1:0]                     col_dir,
    input  logic [1:0]                     row_dir,
    input  logic [COORD_BITS:0]            twice_dcol,
    input  logic [COORD_BITS:0]            twice_drow,
    input  logic [COORD_BITS+2:0]          decision,
    input  logic                           row_major,
    output logic [COORD_BITS-1:0]          next_col,
    output logic [COORD_BITS-1:0]          next_row,
    output logic [COORD_BITS+2:0]          next_decision,
    output logic [bls_pkg::ADDR_BITS-1:0]  byte_address,
    output logic                           last_pixel
);

    localparam int PROD_W = bls_pkg::WIDTH_BITS + COORD_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int TRI_W  = (SUM_W + 2 > bls_pkg::ADDR_BITS) ? SUM_W + 2 : bls_pkg::ADDR_BITS;

    logic [COORD_BITS-1:0] col_step;
    logic [COORD_BITS-1:0] row_step;
    logic [COORD_BITS-1:0] col_moved;
    logic [COORD_BITS-1:0] row_moved;
    logic [COORD_BITS+2:0] dcol_ext;
    logic [COORD_BITS+2:0] drow_ext;
    logic [COORD_BITS+2:0] dec_adj;
    logic                  minor_move;
    logic [PROD_W-1:0]     row_offset;
    logic [SUM_W-1:0]      pixel_index;
    logic [TRI_W-1:0]      index_wide;
    logic [TRI_W-1:0]      triple;

    always_comb begin
        col_step   = {{(COORD_BITS-2){col_dir[1]}}, col_dir};
        row_step   = {{(COORD_BITS-2){row_dir[1]}}, row_dir};
        col_moved  = cur_col + col_step;
        row_moved  = cur_row + row_step;
        dcol_ext   = {2'b00, twice_dcol};
        drow_ext   = {2'b00, twice_drow};
        minor_move = !decision[COORD_BITS+2];

        last_pixel = row_major ? (cur_row == target_row) : (cur_col == target_col);

        if (row_major) begin
            dec_adj       = minor_move ? decision - drow_ext : decision;
            next_decision = dec_adj + dcol_ext;
            next_col      = minor_move ? col_moved : cur_col;
            next_row      = row_moved;
        end else begin
            dec_adj       = minor_move ? decision - dcol_ext : decision;
            next_decision = dec_adj + drow_ext;
            next_col      = col_moved;
            next_row      = minor_move ? row_moved : cur_row;
        end

        // Three bytes per pixel: index times three is index plus twice index.
        row_offset   = PROD_W'(image_width) * PROD_W'(cur_row);
        pixel_index  = SUM_W'(row_offset) + SUM_W'(cur_col);
        index_wide   = TRI_W'(pixel_index);
        triple       = index_wide + (index_wide << 1);
        byte_address = triple[bls_pkg::ADDR_BITS-1:0];
    end

endmodule

// File: design/bls_checker.sv
// ----------------------------------------------------------------------------
// Bresenham line stepper checker
// Port-level properties of the line stepper, attached to the top level.
// ----------------------------------------------------------------------------
module bls_checker #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_wr_en,
    input logic [bls_pkg::WIDTH_BITS-1:0] cfg_wr_data,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           s_mode,
    input logic [COORD_BITS-1:0]          s_start_x,
    input logic [COORD_BITS-1:0]          s_start_y,
    input logic [COORD_BITS-1:0]          s_end_x,
    input logic [COORD_BITS-1:0]          s_end_y,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [COORD_BITS-1:0]          m_pixel_x,
    input logic [COORD_BITS-1:0]          m_pixel_y,
    input logic [bls_pkg::ADDR_BITS-1:0]  m_byte_address,
    input logic                           m_last_pixel
);

    logic step_beat;

    assign step_beat = s_valid && s_ready && (s_mode == bls_pkg::MODE_STEP);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
            && $stable(m_byte_address) && $stable(m_last_pixel))
        else $error("result beat changed while stalled");

    // Reset empties the result register.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With the result register empty the input side never stalls.
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // A result appearing after an idle output comes from a step beat that
    // went through the input register before reaching the result register.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(step_beat, 2))
        else $error("result without a matching step beat");

    // Configuration writes and load endpoints carry no port-level rule.
    logic unused_ok;
    assign unused_ok = ^{cfg_wr_en, cfg_wr_data, s_start_x, s_start_y, s_end_x, s_end_y};

endmodule

bind bresenham_line_stepper_top bls_checker #(
    .COORD_BITS (COORD_BITS)
) u_bls_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_mode         (s_mode),
    .s_start_x      (s_start_x),
    .s_start_y      (s_start_y),
    .s_end_x        (s_end_x),
    .s_end_y        (s_end_y),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_pixel_x      (m_pixel_x),
    .m_pixel_y      (m_pixel_y),
    .m_byte_address (m_byte_address),
    .m_last_pixel   (m_last_pixel)
);

// File: tb/bls_pixel_checker.sv
// ----------------------------------------------------------------------------
// Line stepper pixel checker
// Watches the load/step channel, the pixel channel and the width register
// writes, predicts each pixel of the current line and compares every
// result beat field by field with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module bls_pixel_checker #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bls_pkg::WIDTH_BITS-1:0] cfg_wr_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_mode,
    input  logic [COORD_BITS-1:0]          s_start_x,
    input  logic [COORD_BITS-1:0]          s_start_y,
    input  logic [COORD_BITS-1:0]          s_end_x,
    input  logic [COORD_BITS-1:0]          s_end_y,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [COORD_BITS-1:0]          m_pixel_x,
    input  logic [COORD_BITS-1:0]          m_pixel_y,
    input  logic [bls_pkg::ADDR_BITS-1:0]  m_byte_address,
    input  logic                           m_last_pixel,
    output int                             fail_count,
    output int                             pixels_due
);
    import bls_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [ADDR_BITS-1:0]  addr;
        logic                  last;
    } pixel_t;

    logic [COORD_BITS-1:0]          col, row, goal_col, goal_row;
    logic [1:0]                     col_step, row_step;
    logic [COORD_BITS:0]            span2_col, span2_row;
    logic signed [COORD_BITS+2:0]   err_term;
    logic                           rows_lead, line_live;
    logic [WIDTH_BITS-1:0]          row_pixels;
    pixel_t                         pixel_fifo[$];
    pixel_t                         want;

    function automatic logic [COORD_BITS-1:0] step_coord(input logic [COORD_BITS-1:0] c,
                                                         input logic [1:0] dir);
        return c + {{(COORD_BITS-2){dir[1]}}, dir};
    endfunction

    task automatic set_up_line(input logic [COORD_BITS-1:0] x0, y0, x1, y1);
        int dx, dy;
        dx = int'(x1) - int'(x0);
        dy = int'(y1) - int'(y0);
        col_step = (dx > 0) ? DIR_POS : ((dx < 0) ? DIR_NEG : DIR_NONE);
        row_step = (dy > 0) ? DIR_POS : ((dy < 0) ? DIR_NEG : DIR_NONE);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        span2_col = (COORD_BITS+1)'(2 * dx);
        span2_row = (COORD_BITS+1)'(2 * dy);
        rows_lead = dy > dx;
        err_term = (COORD_BITS+3)'(rows_lead ? (2 * dx - dy) : (2 * dy - dx));
        col = x0;
        row = y0;
        goal_col = x1;
        goal_row = y1;
        line_live = 1'b1;
    endtask

    task automatic predict_pixel();
        pixel_t px;
        px.x = col;
        px.y = row;
        px.addr = ADDR_BITS'(3 * (longint'(col) + longint'(row_pixels) * longint'(row)));
        px.last = rows_lead ? (row == goal_row) : (col == goal_col);
        pixel_fifo.push_back(px);
        if (px.last) begin
            line_live = 1'b0;
        end else if (!rows_lead) begin
            if (err_term >= 0) begin
                err_term = err_term - span2_col;
                row = step_coord(row, row_step);
            end
            col = step_coord(col, col_step);
            err_term = err_term + span2_row;
        end else begin
            if (err_term >= 0) begin
                err_term = err_term - span2_row;
                col = step_coord(col, col_step);
            end
            row = step_coord(row, row_step);
            err_term = err_term + span2_col;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            col = '0;
            row = '0;
            goal_col = '0;
            goal_row = '0;
            col_step = DIR_NONE;
            row_step = DIR_NONE;
            span2_col = '0;
            span2_row = '0;
            err_term = '0;
            rows_lead = 1'b0;
            line_live = 1'b0;
            row_pixels = WIDTH_RESET;
            pixel_fifo.delete();
        end else begin
            if (cfg_wr_en) begin
                row_pixels = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (pixel_fifo.size() == 0) begin
                    $error("pixel beat with no pixel expected: x %0d y %0d", m_pixel_x,
                           m_pixel_y);
                    fail_count++;
                end else begin
                    want = pixel_fifo.pop_front();
                    if (m_pixel_x !== want.x) begin
                        $error("pixel_x: expected %0d, actual %0d", want.x, m_pixel_x);
                        fail_count++;
                    end
                    if (m_pixel_y !== want.y) begin
                        $error("pixel_y: expected %0d, actual %0d", want.y, m_pixel_y);
                        fail_count++;
                    end
                    if (m_byte_address !== want.addr) begin
                        $error("byte_address: expected %0d, actual %0d", want.addr,
                               m_byte_address);
                        fail_count++;
                    end
                    if (m_last_pixel !== want.last) begin
                        $error("last_pixel: expected %0d, actual %0d", want.last,
                               m_last_pixel);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (mode_t'(s_mode) == MODE_LOAD) begin
                    set_up_line(s_start_x, s_start_y, s_end_x, s_end_y);
                end else if (line_live) begin
                    predict_pixel();
                end
            end
        end
        pixels_due <= pixel_fifo.size();
    end

endmodule

// File: tb/tb_bresenham_line_stepper_top.sv
// ----------------------------------------------------------------------------
// Line stepper testbench
// Drives load and step beats through short directed lines and then random
// lines under several image widths, with random gaps on both channels and
// one long hold-off on the pixel channel. The pixel checker predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_bresenham_line_stepper_top;
    import bls_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int COORD_MAX   = (1 << CB) - 1;
    localparam int PHASE_ITEMS = 285;
    localparam int STALL_LIMIT = 2000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [WIDTH_BITS-1:0] cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_mode = 1'b0;
    logic [CB-1:0]         s_start_x = '0;
    logic [CB-1:0]         s_start_y = '0;
    logic [CB-1:0]         s_end_x = '0;
    logic [CB-1:0]         s_end_y = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CB-1:0]         m_pixel_x;
    logic [CB-1:0]         m_pixel_y;
    logic [ADDR_BITS-1:0]  m_byte_address;
    logic                  m_last_pixel;

    int fail_count;
    int pixels_due;
    int beats_sent = 0;

    always #10 aclk = ~aclk;

    bresenham_line_stepper_top #(.COORD_BITS(CB)) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_byte_address (m_byte_address),
        .m_last_pixel   (m_last_pixel)
    );

    bls_pixel_checker #(.COORD_BITS(CB)) pixel_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_byte_address (m_byte_address),
        .m_last_pixel   (m_last_pixel),
        .fail_count     (fail_count),
        .pixels_due     (pixels_due)
    );

    task automatic send_beat(input mode_t mode, input logic [CB-1:0] x0, y0, x1, y1);
        while (!(beats_sent >= 800 && beats_sent < 1100) && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_start_x <= x0;
        s_start_y <= y0;
        s_end_x   <= x1;
        s_end_y   <= y1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic step_beats(input int n);
        for (int i = 0; i < n; i++) begin
            send_beat(MODE_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
        end
    endtask

    task automatic run_line(input logic [CB-1:0] x0, y0, x1, y1, input int steps);
        send_beat(MODE_LOAD, x0, y0, x1, y1);
        step_beats(steps);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixels_due != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_width(input logic [WIDTH_BITS-1:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Pixel side: random back-pressure, one long hold-off and one calm stretch.
    initial begin
        int m_beats;
        int hold_left;
        bit held;
        m_beats = 0;
        hold_left = 0;
        held = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) m_beats++;
            if (!held && m_beats >= 150) begin
                held = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (m_beats >= 1000 && m_beats < 1300) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 29);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("bresenham_line_stepper_top: mismatch");
        $finish;
    end

    initial begin
        logic [WIDTH_BITS-1:0] width_plan [5];
        logic [CB-1:0] x0, y0, x1, y1;
        int dx, dy, e, pick, span, steps, items;
        width_plan = '{11'd1, 11'd1024, 11'd2047, 11'd0, 11'd640};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < 7; p++) begin
            if (p > 0) begin
                write_width((p == 6) ? WIDTH_BITS'($urandom_range(1, 1024)) : width_plan[p-1]);
            end
            if (p == 0) begin
                // A step before any load, a zero-length line with a step past its
                // end, and an unfinished line replaced by a new load.
                step_beats(1);
                run_line(10'd1023, 10'd1023, 10'd1023, 10'd1023, 2);
                run_line(10'd0, 10'd0, 10'd3, 10'd1, 2);
                run_line(10'd1023, 10'd0, 10'd1021, 10'd3, 4);
                run_line(10'd5, 10'd5, 10'd2, 10'd2, 4);
                run_line(10'd0, 10'd1023, 10'd0, 10'd1021, 3);
                run_line(10'd1021, 10'd512, 10'd1023, 10'd512, 3);
            end
            items = 0;
            while (items < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                x0 = CB'($urandom);
                y0 = CB'($urandom);
                if (pick < 5) begin
                    send_beat(mode_t'($urandom_range(1)), x0, y0, CB'($urandom), CB'($urandom));
                end else begin
                    if (pick < 6) begin
                        x1 = CB'($urandom);
                        y1 = CB'($urandom);
                    end else begin
                        dx = int'($urandom_range(32)) - 16;
                        dy = int'($urandom_range(32)) - 16;
                        if (pick < 15) dy = 0;
                        else if (pick < 22) dx = 0;
                        else if (pick < 32) dy = (pick % 2) ? dx : -dx;
                        e = int'(x0) + dx;
                        x1 = (e < 0) ? '0 : ((e > COORD_MAX) ? CB'(COORD_MAX) : CB'(e));
                        e = int'(y0) + dy;
                        y1 = (e < 0) ? '0 : ((e > COORD_MAX) ? CB'(COORD_MAX) : CB'(e));
                    end
                    dx = int'(x1) - int'(x0);
                    dy = int'(y1) - int'(y0);
                    if (dx < 0) dx = -dx;
                    if (dy < 0) dy = -dy;
                    span = ((dx > dy) ? dx : dy) + 1;
                    pick = $urandom_range(99);
                    if (pick < 70) steps = span;
                    else if (pick < 82) steps = span + $urandom_range(1, 3);
                    else steps = $urandom_range(0, span - 1);
                    run_line(x0, y0, x1, y1, steps);
                    items += 1 + ((steps < span) ? steps : span);
                end
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("bresenham_line_stepper_top: match");
        end else begin
            $display("bresenham_line_stepper_top: mismatch");
        end
        $finish;
    end

endmodule
